// ===== rtl/amf_pkg.sv =====
package amf_pkg;

  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned MaxWindowDef = 7;

  localparam int unsigned CoordW = 14;
  localparam int unsigned CfgW   = 9;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1,
    CfgWindowStart = 2'd2,
    CfgWindowLimit = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StWin,
    StIssue,
    StDrain,
    StStep,
    StDecide,
    StFinish
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load_query;
    logic win_init;
    logic pass_init;
    logic issue;
    logic pass_end;
    logic next_win;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic query_req;
    logic last_tap;
    logic last_bit;
    logic done;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/amf_in_if.sv =====
interface amf_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] pixel;

  modport source (output valid, operation, row, col, pixel, input ready);
  modport sink   (input valid, operation, row, col, pixel, output ready);
endinterface

// ===== rtl/amf_out_if.sv =====
interface amf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_value;
  logic [2:0] window_used;
  logic       kept_original;

  modport source (output valid, filtered_value, window_used, kept_original, input ready);
  modport sink   (input valid, filtered_value, window_used, kept_original, output ready);
endinterface

// ===== rtl/amf_ctrl.sv =====
module amf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  amf_pkg::sts_t sts_i,
  output amf_pkg::cmd_t cmd_o
);

  amf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amf_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      amf_pkg::StIdle: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.query_req) begin
          cmd_o.load_query = 1'b1;
          state_d = amf_pkg::StWin;
        end
      end
      amf_pkg::StWin: begin
        cmd_o.win_init = 1'b1;
        state_d = amf_pkg::StIssue;
      end
      amf_pkg::StIssue: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_tap) state_d = amf_pkg::StDrain;
      end
      amf_pkg::StDrain: begin
        state_d = amf_pkg::StStep;
      end
      amf_pkg::StStep: begin
        cmd_o.pass_end  = 1'b1;
        cmd_o.pass_init = 1'b1;
        state_d = sts_i.last_bit ? amf_pkg::StDecide : amf_pkg::StIssue;
      end
      amf_pkg::StDecide: begin
        if (sts_i.done) begin
          state_d = amf_pkg::StFinish;
        end else begin
          cmd_o.next_win = 1'b1;
          state_d = amf_pkg::StWin;
        end
      end
      amf_pkg::StFinish: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = amf_pkg::StIdle;
        end
      end
      default: state_d = amf_pkg::StIdle;
    endcase
  end

endmodule

// ===== rtl/amf_dp.sv =====
module amf_dp #(
  parameter int unsigned MAX_WIDTH  = amf_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = amf_pkg::MaxHeightDef,
  parameter int unsigned MAX_WINDOW = amf_pkg::MaxWindowDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  amf_in_if.sink                    in_if,
  amf_out_if.source                 out_if,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [amf_pkg::CfgW-1:0]  cfg_data_i,
  input  amf_pkg::cmd_t             cmd_i,
  output amf_pkg::sts_t             sts_o
);

  localparam int unsigned WinCap = MAX_WINDOW - 1 + (MAX_WINDOW % 2);
  localparam int unsigned NW     = $clog2(WinCap + 3);
  localparam int unsigned PW     = NW + 1;
  localparam int unsigned KW     = $clog2(WinCap * WinCap + 1);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT);
  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned AW     = RW + CW;
  localparam int unsigned CdW    = amf_pkg::CoordW;

  logic [8:0] cfg_w_q, cfg_h_q;
  logic [2:0] cfg_st_q, cfg_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= 9'd256;
      cfg_h_q   <= 9'd256;
      cfg_st_q  <= 3'd3;
      cfg_lim_q <= 3'd7;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        amf_pkg::CfgFrameWidth:  cfg_w_q   <= cfg_data_i;
        amf_pkg::CfgFrameHeight: cfg_h_q   <= cfg_data_i;
        amf_pkg::CfgWindowStart: cfg_st_q  <= cfg_data_i[2:0];
        amf_pkg::CfgWindowLimit: cfg_lim_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // effective frame size and window range
  logic [CdW-1:0] w_eff, h_eff;
  logic [NW-1:0]  st_eff, lim_a, lim_b, lim_eff;
  logic [2:0]     lim_odd;

  always_comb begin
    w_eff = CdW'(cfg_w_q);
    if (w_eff > CdW'(MAX_WIDTH)) w_eff = CdW'(MAX_WIDTH);
    h_eff = CdW'(cfg_h_q);
    if (h_eff > CdW'(MAX_HEIGHT)) h_eff = CdW'(MAX_HEIGHT);
    st_eff = NW'(cfg_st_q | 3'd1);
    if (st_eff > NW'(WinCap)) st_eff = NW'(WinCap);
    lim_odd = (cfg_lim_q[0] || cfg_lim_q == 3'd0) ? cfg_lim_q : cfg_lim_q - 3'd1;
    lim_a = NW'(lim_odd);
    lim_b = (lim_a > NW'(WinCap)) ? NW'(WinCap) : lim_a;
    lim_eff = (lim_b < st_eff) ? st_eff : lim_b;
  end

  // frame store
  logic [7:0]    mem [2**AW];
  logic [7:0]    rdata_q;
  logic [CdW-1:0] ld_r, ld_c;
  logic           ld_we;

  assign ld_r  = CdW'(in_if.row);
  assign ld_c  = CdW'(in_if.col);
  assign ld_we = in_if.valid && cmd_i.in_ready && (in_if.operation == amf_pkg::OpLoad)
                 && ld_r < CdW'(MAX_HEIGHT) && ld_c < CdW'(MAX_WIDTH);

  // query registers
  logic [7:0]           row_q, col_q;
  logic [NW-1:0]        n_q, half;
  logic signed [PW-1:0] p_q, q_q, hneg;
  logic [2:0]           bit_q;
  logic [7:0]           pref_q, mn_q, mx_q, ctr_q;
  logic [KW-1:0]        rank_q, cnt_q;
  logic                 rv_q, pad_q, cen_q;

  logic signed [CdW-1:0] r_tap, c_tap;
  logic                  in_frame;
  logic [AW-1:0]         rd_addr;

  assign half  = n_q >> 1;
  assign hneg  = -$signed(PW'(half));
  assign r_tap = $signed(CdW'(row_q)) + CdW'(p_q);
  assign c_tap = $signed(CdW'(col_q)) + CdW'(q_q);
  assign in_frame = r_tap >= 0 && c_tap >= 0 &&
                    r_tap < $signed(h_eff) && c_tap < $signed(w_eff);
  assign rd_addr = {r_tap[RW-1:0], c_tap[CW-1:0]};

  always_ff @(posedge clk_i) begin
    if (ld_we) mem[{ld_r[RW-1:0], ld_c[CW-1:0]}] <= in_if.pixel;
    rdata_q <= mem[rd_addr];
  end

  logic [7:0] v;
  logic       match;
  logic [2*NW-1:0] nsq;

  assign v     = pad_q ? 8'd0 : rdata_q;
  assign match = ((v ^ pref_q) & (8'hFF << bit_q)) == 8'd0;
  assign nsq   = n_q * n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    pad_q <= !in_frame;
    cen_q <= p_q == 0 && q_q == 0;
    if (cmd_i.load_query) begin
      row_q <= in_if.row;
      col_q <= in_if.col;
      n_q   <= st_eff;
    end
    if (cmd_i.next_win) n_q <= n_q + NW'(2);
    if (cmd_i.win_init) begin
      bit_q  <= 3'd7;
      pref_q <= 8'd0;
      rank_q <= KW'(nsq >> 1);
      mn_q   <= 8'hFF;
      mx_q   <= 8'd0;
      cnt_q  <= '0;
      p_q    <= hneg;
      q_q    <= hneg;
    end
    if (cmd_i.issue) begin
      if (q_q == $signed(PW'(half))) begin
        q_q <= hneg;
        p_q <= p_q + PW'(1);
      end else begin
        q_q <= q_q + PW'(1);
      end
    end
    if (rv_q) begin
      if (match) cnt_q <= cnt_q + KW'(1);
      if (cen_q) ctr_q <= v;
      if (bit_q == 3'd7) begin
        if (v < mn_q) mn_q <= v;
        if (v > mx_q) mx_q <= v;
      end
    end
    if (cmd_i.pass_end) begin
      if (rank_q >= cnt_q) begin
        rank_q <= rank_q - cnt_q;
        pref_q[bit_q] <= 1'b1;
      end
      bit_q <= bit_q - 3'd1;
    end
    if (cmd_i.pass_init) begin
      cnt_q <= '0;
      p_q   <= hneg;
      q_q   <= hneg;
    end
  end

  logic settle, keep;
  assign settle = mn_q < pref_q && pref_q < mx_q;
  assign keep   = settle && mn_q < ctr_q && ctr_q < mx_q;

  logic       ov_q;
  logic [7:0] oval_q;
  logic [2:0] owin_q;
  logic       okeep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_if.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      oval_q  <= keep ? ctr_q : pref_q;
      owin_q  <= n_q[2:0];
      okeep_q <= keep;
    end
  end

  assign out_if.valid          = ov_q;
  assign out_if.filtered_value = oval_q;
  assign out_if.window_used    = owin_q;
  assign out_if.kept_original  = okeep_q;
  assign in_if.ready           = cmd_i.in_ready;

  assign sts_o.query_req = in_if.valid && (in_if.operation == amf_pkg::OpQuery);
  assign sts_o.last_tap  = p_q == $signed(PW'(half)) && q_q == $signed(PW'(half));
  assign sts_o.last_bit  = bit_q == 3'd0;
  assign sts_o.done      = settle || (n_q + NW'(2) > lim_eff);
  assign sts_o.out_busy  = ov_q && !out_if.ready;

endmodule

// ===== rtl/adaptive_median_filter.sv =====
// Adaptive median filter over a stored 8-bit frame.
// in_if carries one transaction per item: operation 0 writes pixel at
// (row, col) into the frame store and gives no result; operation 1
// filters at (row, col) and gives one transaction on out_if.
// A query runs window by window, side n from window_start up to
// window_limit in steps of 2. Each window takes 8 bit passes of the
// median select, each reading all n*n taps through the single read port
// of the frame store.
// in_if.ready is high only while no query is in progress.
// The result sits in an output register; a stalled receiver holds the next
// query in its final step, during which no loads are taken.
// Reset clears control and loads the registers with 256, 256, 3, 7; the
// frame store is not cleared and must be written before it is read.
// Configuration writes go through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must make them only while the block is idle, as the block does not enforce it.
module adaptive_median_filter #(
  parameter int unsigned MAX_WIDTH  = amf_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = amf_pkg::MaxHeightDef,
  parameter int unsigned MAX_WINDOW = amf_pkg::MaxWindowDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  amf_in_if.sink                   in_if,
  amf_out_if.source                out_if,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [amf_pkg::CfgW-1:0] cfg_data_i
);

  amf_pkg::cmd_t cmd;
  amf_pkg::sts_t sts;

  amf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  amf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  typedef struct {
    amf_pkg::op_e op;
    logic [7:0]   row;
    logic [7:0]   col;
    logic [7:0]   pix;
    bit           typed;
    logic [7:0]   val;
    logic [2:0]   win;
    logic         keep;
  } item_t;

  typedef struct {
    logic [7:0] val;
    logic [2:0] win;
    logic       keep;
  } filt_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [1:0]               cfg_idx_i;
  logic [amf_pkg::CfgW-1:0] cfg_data_i;

  amf_in_if  in_ch ();
  amf_out_if out_ch ();

  adaptive_median_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  logic [7:0] frame_mem [65536];
  bit         written [65536];
  int         cfg_w = 256, cfg_h = 256, cfg_start = 3, cfg_lim = 7;
  filt_t      filt_q[$];
  int         errs = 0, n_loads = 0, n_queries = 0, n_results = 0, n_kept = 0;
  int         burst_left = 0;
  bit         idle_on = 0;
  int         ready_pct = 100;
  bit         hold_req = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report(string msg);
    errs++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void eff_sizes(output int w, output int h, output int st, output int lm);
    w  = cfg_w > 256 ? 256 : cfg_w;
    h  = cfg_h > 256 ? 256 : cfg_h;
    st = cfg_start | 1;
    lm = cfg_lim;
    if (lm % 2 == 0 && lm > 0) lm--;
    if (st > 7) st = 7;
    if (lm > 7) lm = 7;
    if (lm < st) lm = st;
  endfunction

  function automatic int pix_at(int r, int c, int h, int w);
    if (r < 0 || c < 0 || r >= h || c >= w) return 0;
    return frame_mem[r * 256 + c];
  endfunction

  function automatic bit taps_written(int r, int c);
    int w, h, st, lm, hf;
    eff_sizes(w, h, st, lm);
    hf = lm / 2;
    for (int p = r - hf; p <= r + hf; p++)
      for (int q = c - hf; q <= c + hf; q++)
        if (p >= 0 && q >= 0 && p < h && q < w && !written[p * 256 + q]) return 0;
    return 1;
  endfunction

  function automatic filt_t adaptive_median(int r, int c);
    int w, h, st, lm, n, hf, k, j, x, ctr, mn, mx, med;
    int win [49];
    filt_t o;
    eff_sizes(w, h, st, lm);
    ctr = pix_at(r, c, h, w);
    n = st;
    forever begin
      hf = (n - 1) / 2;
      k = 0;
      for (int p = -hf; p <= hf; p++)
        for (int q = -hf; q <= hf; q++) begin
          win[k] = pix_at(r + p, c + q, h, w);
          k++;
        end
      for (int i = 1; i < k; i++) begin
        x = win[i];
        j = i - 1;
        while (j >= 0 && win[j] > x) begin
          win[j + 1] = win[j];
          j--;
        end
        win[j + 1] = x;
      end
      mn = win[0];
      mx = win[k - 1];
      med = win[k / 2];
      if (mn < med && med < mx) begin
        o.keep = (mn < ctr && ctr < mx);
        o.val = o.keep ? ctr[7:0] : med[7:0];
        o.win = n[2:0];
        return o;
      end
      if (n + 2 > lm) begin
        o.val = med[7:0];
        o.win = n[2:0];
        o.keep = 0;
        return o;
      end
      n += 2;
    end
  endfunction

  // one transaction on in_ch; caller sits at a rising edge
  task automatic send_item(item_t it);
    bit ok;
    filt_t e;
    if (idle_on && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= it.op;
    in_ch.row       <= it.row;
    in_ch.col       <= it.col;
    in_ch.pixel     <= it.pix;
    do begin
      @(negedge clk_i);
      ok = in_ch.ready;
      if (ok) begin
        if (it.op == amf_pkg::OpLoad) begin
          frame_mem[{it.row, it.col}] = it.pix;
          n_loads++;
        end else begin
          if (it.typed) begin
            e.val = it.val;
            e.win = it.win;
            e.keep = it.keep;
          end else begin
            e = adaptive_median(it.row, it.col);
          end
          filt_q.push_back(e);
          n_queries++;
        end
      end
      @(posedge clk_i);
    end while (!ok);
    if (burst_left > 0) burst_left--;
  endtask

  function automatic item_t load_item(int r, int c, int p);
    item_t it;
    it = '{op: amf_pkg::OpLoad, row: r[7:0], col: c[7:0], pix: p[7:0], typed: 0,
           val: 0, win: 0, keep: 0};
    written[r * 256 + c] = 1;
    return it;
  endfunction

  function automatic int rand_pix();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 255;
      2: return $urandom_range(100, 140);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic drain(int extra);
    while (filt_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(amf_pkg::cfg_idx_e idx, int data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data[amf_pkg::CfgW-1:0];
    @(posedge clk_i);
  endtask

  task automatic set_cfg(int w, int h, int s, int l);
    in_ch.valid <= 1'b0;
    drain(20);
    write_reg(amf_pkg::CfgFrameWidth, w);
    write_reg(amf_pkg::CfgFrameHeight, h);
    write_reg(amf_pkg::CfgWindowStart, s);
    write_reg(amf_pkg::CfgWindowLimit, l);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_w = w & 9'h1FF;
    cfg_h = h & 9'h1FF;
    cfg_start = s & 7;
    cfg_lim = l & 7;
  endtask

  task automatic run_phase(int w, int h, int s, int l, int fr, int fc, int nrand,
                           int rpct, bit idle, bit hold);
    item_t it;
    int r, c;
    bit done;
    set_cfg(w, h, s, l);
    ready_pct = rpct;
    idle_on = idle;
    for (int i = 0; i < fr; i++)
      for (int j = 0; j < fc; j++) send_item(load_item(i, j, rand_pix()));
    if (hold) hold_req = 1;
    for (int n = 0; n < nrand; n++) begin
      done = 0;
      if ($urandom_range(0, 99) < 55) begin
        for (int t = 0; t < 8 && !done; t++) begin
          r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, (fr + 3 > 255) ? 255 : fr + 3);
          c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, (fc + 3 > 255) ? 255 : fc + 3);
          if (taps_written(r, c)) begin
            it = '{op: amf_pkg::OpQuery, row: r[7:0], col: c[7:0],
                   pix: 8'($urandom_range(0, 255)), typed: 0, val: 0, win: 0, keep: 0};
            done = 1;
          end
        end
      end
      if (!done) begin
        if ($urandom_range(0, 4) == 0) begin
          r = $urandom_range(0, 255);
          c = $urandom_range(0, 255);
        end else begin
          r = $urandom_range(0, fr > 0 ? fr - 1 : 3);
          c = $urandom_range(0, fc > 0 ? fc - 1 : 3);
        end
        it = load_item(r, c, rand_pix());
      end
      send_item(it);
    end
  endtask

  always @(negedge clk_i) begin
    filt_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.kept_original) n_kept++;
      if (filt_q.size() == 0) begin
        report("result with no query outstanding");
      end else begin
        e = filt_q.pop_front();
        if (out_ch.filtered_value !== e.val)
          report($sformatf("filtered_value %0d, want %0d", out_ch.filtered_value, e.val));
        if (out_ch.window_used !== e.win)
          report($sformatf("window_used %0d, want %0d", out_ch.window_used, e.win));
        if (out_ch.kept_original !== e.keep)
          report($sformatf("kept_original %0b, want %0b", out_ch.kept_original, e.keep));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  item_t dir_rows [15];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = amf_pkg::OpLoad;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.pixel = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = amf_pkg::CfgFrameWidth;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      '{amf_pkg::OpLoad,  8'd0,   8'd0,   8'd255, 0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpLoad,  8'd0,   8'd1,   8'd255, 0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpLoad,  8'd1,   8'd0,   8'd255, 0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpLoad,  8'd1,   8'd1,   8'd255, 0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpQuery, 8'd0,   8'd0,   8'd0,   1, 8'd0, 3'd7, 1'b0},
      '{amf_pkg::OpQuery, 8'd200, 8'd200, 8'd255, 1, 8'd0, 3'd7, 1'b0},
      '{amf_pkg::OpQuery, 8'd255, 8'd255, 8'd0,   1, 8'd0, 3'd7, 1'b0},
      '{amf_pkg::OpLoad,  8'd1,   8'd1,   8'd0,   0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpQuery, 8'd0,   8'd0,   8'd0,   0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpLoad,  8'd0,   8'd0,   8'h80,  0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpQuery, 8'd1,   8'd1,   8'd0,   0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpQuery, 8'd0,   8'd1,   8'd0,   0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpLoad,  8'd255, 8'd255, 8'hAA,  0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpLoad,  8'd255, 8'd0,   8'h55,  0, 8'd0, 3'd0, 1'b0},
      '{amf_pkg::OpQuery, 8'd2,   8'd2,   8'd0,   0, 8'd0, 3'd0, 1'b0}
    };
    set_cfg(2, 2, 3, 7);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == amf_pkg::OpLoad) written[{dir_rows[i].row, dir_rows[i].col}] = 1;
      send_item(dir_rows[i]);
    end

    run_phase(256, 1, 1, 7, 1, 256, 40, 100, 0, 0);
    run_phase(1, 256, 0, 0, 256, 1, 40, 70, 1, 0);
    run_phase(8, 8, 2, 6, 8, 8, 70, 50, 1, 0);
    run_phase(16, 12, 5, 3, 12, 16, 70, 80, 1, 1);
    run_phase(0, 0, 7, 7, 0, 0, 40, 30, 1, 0);
    run_phase(511, 300, 4, 2, 0, 0, 60, 90, 0, 0);
    run_phase(5, 7, 1, 3, 7, 5, 70, 60, 1, 0);

    in_ch.valid <= 1'b0;
    drain(800);
    $display("Covered %0d pixel loads and %0d filter queries over 8 register settings,",
             n_loads, n_queries);
    $display("%0d results checked (%0d kept the centre pixel), %0d mismatches.",
             n_results, n_kept, errs);
    if (errs == 0 && filt_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
